>>> rtl/pdrm_pkg.sv
// Types, command and status codes, and sequencer states for the descriptor ring manager.
package pdrm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_UNPUB     = 3'd3;
  localparam logic [2:0] ST_LAPPED    = 3'd4;

  localparam logic [1:0] CFG_SLOTS  = 2'd0;
  localparam logic [1:0] CFG_ARENA  = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_ALIGN  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_SIZE,
    S_WR_STRIDE,
    S_WR_CHECK,
    S_WR_PHYS_DIV,
    S_WR_PLACE,
    S_WR_COMMIT,
    S_WR_ADV,
    S_WR_SLOT_DIV,
    S_WR_SLOT_SET,
    S_RD_DIV,
    S_RD_FETCH,
    S_RD_SUM,
    S_RD_CHECK,
    S_IDX_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        payload_bytes;
    logic [31:0]        meta_bytes;
    logic [7:0]         packet_kind;
    logic signed [31:0] track_id;
    logic signed [63:0] timestamp;
    logic signed [31:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         slot;
    logic [31:0]        arena_offset;
    logic [62:0]        record_cursor;
    logic [31:0]        rec_payload_bytes;
    logic [31:0]        rec_meta_bytes;
    logic [7:0]         rec_kind;
    logic signed [31:0] rec_track;
    logic signed [63:0] rec_timestamp;
    logic [62:0]        rec_seq;
    logic [62:0]        cursor_now;
    logic [62:0]        seq_now;
  } rsp_t;

  typedef struct packed {
    logic [31:0]        offset;
    logic [31:0]        payload_len;
    logic [31:0]        meta_len;
    logic [62:0]        start_cursor;
    logic signed [63:0] timestamp;
    logic [7:0]         kind;
    logic signed [31:0] track;
    logic [62:0]        seq;
  } desc_t;

endpackage

>>> rtl/packet_descriptor_ring_manager.sv
// Descriptor ring manager: sequencer, shared remainder unit and descriptor memory.
//
// Request channel (req_valid/req_stall/req) takes one command: write record,
// read descriptor, set slot pointer or query a slot relative to the pointer.
// Response channel (rsp_valid/rsp_stall/rsp) returns one result per command.
// Configuration is a plain write port (cfg_we/cfg_index/cfg_data) used while idle.
// Every command but a failed write runs through one restoring remainder unit,
// one quotient bit per cycle. Reads, sets and queries reduce an index; a
// write reduces the arena cursor and then the advanced slot pointer. One
// command is in flight at a time; req_stall is high from accept until the
// response is loaded into the output register. The next command is
// accepted the cycle after that load. A finished response waits in the
// output register while the next command is accepted; the sequencer holds
// its result until rsp_stall lets it through.
// Reset (rst, synchronous) clears the pointer, cursor, sequence count, the
// published bits of all slots and loads the configuration defaults; there is
// no clearing pass.
module packet_descriptor_ring_manager #(
  parameter int MAX_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pdrm_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pdrm_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [32:0]    cfg_data
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  pdrm_pkg::state_t state, state_next;

  // configuration
  logic [6:0]  slots_in_use;
  logic [32:0] arena_bytes;
  logic [32:0] record_limit;
  logic [3:0]  align_shift;

  // ring state
  logic [SLOT_W-1:0]    ws;
  logic [62:0]          abs_cursor;
  logic [62:0]          pcount;
  logic [MAX_SLOTS-1:0] pub;

  // work registers
  pdrm_pkg::req_t  req_r;
  pdrm_pkg::rsp_t  res;
  pdrm_pkg::rsp_t  rsp_load;
  pdrm_pkg::desc_t mem [MAX_SLOTS];
  pdrm_pkg::desc_t mem_rd;
  logic [32:0]       rec;
  logic [33:0]       stride;
  logic              over;
  logic [32:0]       gap;
  logic [62:0]       start_r;
  logic [31:0]       phys_r;
  logic [62:0]       seq_r;
  logic [SLOT_W-1:0] kr;
  logic [33:0]       sum;
  logic [62:0]       lag;

  // remainder unit
  logic [62:0] dvd;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic        div_run;
  logic [32:0] dsr;
  logic [33:0] rem_sh, rem_nx;
  logic [32:0] red33;
  logic [SLOT_W-1:0] red;

  // derived configuration
  logic [32:0] n33;
  logic [3:0]  ashift;
  logic [33:0] amask;
  logic [32:0] arena;
  logic        wr_err;

  // signed value to reduce at accept time
  logic signed [32:0] idx_v;
  logic [32:0]        idx_mag;

  // clamp configuration to its used range
  always_comb begin
    if (slots_in_use == 7'd0) begin
      n33 = 33'd1;
    end else if (33'(slots_in_use) > 33'(MAX_SLOTS)) begin
      n33 = 33'(MAX_SLOTS);
    end else begin
      n33 = 33'(slots_in_use);
    end
    if (align_shift < 4'd3) begin
      ashift = 4'd3;
    end else if (align_shift > 4'd12) begin
      ashift = 4'd12;
    end else begin
      ashift = align_shift;
    end
    amask = (34'd1 << ashift) - 34'd1;
    arena = (arena_bytes[32] ? 33'h1_0000_0000 : arena_bytes) & ~amask[32:0];
  end

  // remainder unit step and sign fix
  always_comb begin
    div_run = (state == pdrm_pkg::S_WR_PHYS_DIV) || (state == pdrm_pkg::S_WR_SLOT_DIV) ||
              (state == pdrm_pkg::S_RD_DIV) || (state == pdrm_pkg::S_IDX_DIV);
    dsr     = (state == pdrm_pkg::S_WR_PHYS_DIV) ? arena : n33;
    rem_sh  = {rem[32:0], dvd[62]};
    rem_nx  = (rem_sh >= {1'b0, dsr}) ? rem_sh - {1'b0, dsr} : rem_sh;
    red33   = (neg && rem != 34'd0) ? n33 - rem[32:0] : rem[32:0];
    red     = red33[SLOT_W-1:0];
  end

  // index to reduce for the accepted command
  always_comb begin
    if (req.cmd == pdrm_pkg::CMD_QUERY) begin
      idx_v = 33'(req.slot_index) + $signed({1'b0, 32'(ws)});
    end else begin
      idx_v = 33'(req.slot_index);
    end
    idx_mag = idx_v[32] ? 33'(-idx_v) : 33'(idx_v);
  end

  assign wr_err = (arena == 33'd0) || (rec == 33'd0) || (rec > record_limit) ||
                  (stride > 34'(arena));

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pdrm_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req.cmd)
            pdrm_pkg::CMD_WRITE: state_next = pdrm_pkg::S_WR_SIZE;
            pdrm_pkg::CMD_READ:  state_next = pdrm_pkg::S_RD_DIV;
            default:             state_next = pdrm_pkg::S_IDX_DIV;
          endcase
        end
      end
      pdrm_pkg::S_WR_SIZE:   state_next = pdrm_pkg::S_WR_STRIDE;
      pdrm_pkg::S_WR_STRIDE: state_next = pdrm_pkg::S_WR_CHECK;
      pdrm_pkg::S_WR_CHECK:  state_next = wr_err ? pdrm_pkg::S_DONE : pdrm_pkg::S_WR_PHYS_DIV;
      pdrm_pkg::S_WR_PHYS_DIV: if (cnt == 6'd1) state_next = pdrm_pkg::S_WR_PLACE;
      pdrm_pkg::S_WR_PLACE:  state_next = pdrm_pkg::S_WR_COMMIT;
      pdrm_pkg::S_WR_COMMIT: state_next = pdrm_pkg::S_WR_ADV;
      pdrm_pkg::S_WR_ADV:    state_next = pdrm_pkg::S_WR_SLOT_DIV;
      pdrm_pkg::S_WR_SLOT_DIV: if (cnt == 6'd1) state_next = pdrm_pkg::S_WR_SLOT_SET;
      pdrm_pkg::S_WR_SLOT_SET: state_next = pdrm_pkg::S_DONE;
      pdrm_pkg::S_RD_DIV:    if (cnt == 6'd1) state_next = pdrm_pkg::S_RD_FETCH;
      pdrm_pkg::S_RD_FETCH:  state_next = pdrm_pkg::S_RD_SUM;
      pdrm_pkg::S_RD_SUM:    state_next = pdrm_pkg::S_RD_CHECK;
      pdrm_pkg::S_RD_CHECK:  state_next = pdrm_pkg::S_DONE;
      pdrm_pkg::S_IDX_DIV:   if (cnt == 6'd1) state_next = pdrm_pkg::S_DONE;
      pdrm_pkg::S_DONE:      if (!rsp_valid || !rsp_stall) state_next = pdrm_pkg::S_IDLE;
      default:               state_next = pdrm_pkg::S_IDLE;
    endcase
  end

  assign req_stall = (state != pdrm_pkg::S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 7'd64;
      arena_bytes  <= 33'd1048576;
      record_limit <= 33'd65536;
      align_shift  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        pdrm_pkg::CFG_SLOTS: slots_in_use <= cfg_data[6:0];
        pdrm_pkg::CFG_ARENA: arena_bytes  <= cfg_data;
        pdrm_pkg::CFG_LIMIT: record_limit <= cfg_data;
        pdrm_pkg::CFG_ALIGN: align_shift  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ring state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      ws         <= '0;
      abs_cursor <= '0;
      pcount     <= '0;
      pub        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == pdrm_pkg::S_WR_ADV) begin
        abs_cursor <= start_r + 63'(stride);
        pcount     <= seq_r;
        pub[ws]    <= 1'b1;
      end
      if (state == pdrm_pkg::S_WR_SLOT_SET) begin
        ws <= red;
      end
      if (state == pdrm_pkg::S_IDX_DIV && cnt == 6'd1 && req_r.cmd == pdrm_pkg::CMD_SET) begin
        ws <= SLOT_W'((neg && rem_nx != 34'd0) ? n33 - rem_nx[32:0] : rem_nx[32:0]);
      end
      if (state == pdrm_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload with the ring counters after the command
  always_comb begin
    rsp_load            = res;
    rsp_load.cursor_now = abs_cursor;
    rsp_load.seq_now    = pcount;
  end

  // response payload: loaded when the output register is free
  always_ff @(posedge clk) begin
    if (state == pdrm_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp <= rsp_load;
    end
  end

  // descriptor memory
  always_ff @(posedge clk) begin
    if (state == pdrm_pkg::S_WR_ADV) begin
      mem[ws] <= '{offset:       phys_r,
                   payload_len:  req_r.payload_bytes,
                   meta_len:     req_r.meta_bytes,
                   start_cursor: start_r,
                   timestamp:    req_r.timestamp,
                   kind:         req_r.packet_kind,
                   track:        req_r.track_id,
                   seq:          seq_r};
    end
    if (state == pdrm_pkg::S_RD_FETCH) begin
      mem_rd <= mem[red];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (div_run) begin
      rem <= rem_nx;
      dvd <= dvd << 1;
      cnt <= cnt - 6'd1;
    end
    case (state)
      pdrm_pkg::S_IDLE: begin
        if (req_valid) begin
          req_r    <= req;
          res      <= '{slot: 6'(ws), default: '0};
          neg      <= idx_v[32];
          dvd      <= {idx_mag, 30'd0};
          rem      <= '0;
          cnt      <= 6'd33;
        end
      end
      pdrm_pkg::S_WR_SIZE: begin
        rec <= 33'(req_r.payload_bytes) + 33'(req_r.meta_bytes);
      end
      pdrm_pkg::S_WR_STRIDE: begin
        stride <= (34'(rec) + amask) & ~amask;
      end
      pdrm_pkg::S_WR_CHECK: begin
        // size checks in priority order, then start the cursor reduction
        if (arena == 33'd0 || rec == 33'd0) begin
          res.status <= pdrm_pkg::ST_BAD_SIZE;
        end else if (rec > record_limit) begin
          res.status <= pdrm_pkg::ST_TOO_LARGE;
        end else if (stride > 34'(arena)) begin
          res.status <= pdrm_pkg::ST_BAD_SIZE;
        end
        neg <= 1'b0;
        dvd <= abs_cursor;
        rem <= '0;
        cnt <= 6'd63;
      end
      pdrm_pkg::S_WR_PLACE: begin
        over <= (35'(rem) + 35'(stride)) > 35'(arena);
        gap  <= arena - rem[32:0];
      end
      pdrm_pkg::S_WR_COMMIT: begin
        // pad to the arena end rather than split the record
        start_r <= over ? abs_cursor + 63'(gap) : abs_cursor;
        phys_r  <= over ? 32'd0 : rem[31:0];
        seq_r   <= pcount + 63'd1;
      end
      pdrm_pkg::S_WR_ADV: begin
        res.status            <= pdrm_pkg::ST_OK;
        res.arena_offset      <= phys_r;
        res.record_cursor     <= start_r;
        res.rec_payload_bytes <= req_r.payload_bytes;
        res.rec_meta_bytes    <= req_r.meta_bytes;
        res.rec_kind          <= req_r.packet_kind;
        res.rec_track         <= req_r.track_id;
        res.rec_timestamp     <= req_r.timestamp;
        res.rec_seq           <= seq_r;
        neg <= 1'b0;
        dvd <= {33'(ws) + 33'd1, 30'd0};
        rem <= '0;
        cnt <= 6'd33;
      end
      pdrm_pkg::S_WR_SLOT_SET: begin
        res.slot <= 6'(red);
      end
      pdrm_pkg::S_RD_FETCH: begin
        kr       <= red;
        res.slot <= 6'(red);
      end
      pdrm_pkg::S_RD_SUM: begin
        sum <= 34'(mem_rd.offset) + 34'(mem_rd.meta_len) + 34'(mem_rd.payload_len);
        lag <= abs_cursor - mem_rd.start_cursor;
      end
      pdrm_pkg::S_RD_CHECK: begin
        if (arena == 33'd0) begin
          res.status <= pdrm_pkg::ST_BAD_SIZE;
        end else if (!pub[kr]) begin
          res.status <= pdrm_pkg::ST_UNPUB;
        end else if (sum > 34'(arena)) begin
          res.status <= pdrm_pkg::ST_BAD_SIZE;
        end else if (lag > 63'(arena)) begin
          res.status <= pdrm_pkg::ST_LAPPED;
        end else begin
          res.status            <= pdrm_pkg::ST_OK;
          res.arena_offset      <= mem_rd.offset;
          res.record_cursor     <= mem_rd.start_cursor;
          res.rec_payload_bytes <= mem_rd.payload_len;
          res.rec_meta_bytes    <= mem_rd.meta_len;
          res.rec_kind          <= mem_rd.kind;
          res.rec_track         <= mem_rd.track;
          res.rec_timestamp     <= mem_rd.timestamp;
          res.rec_seq           <= mem_rd.seq;
        end
      end
      pdrm_pkg::S_IDX_DIV: begin
        if (cnt == 6'd1) begin
          res.slot <= 6'((neg && rem_nx != 34'd0) ? n33 - rem_nx[32:0] : rem_nx[32:0]);
        end
      end
      default: ;
    endcase
  end

  // remainder stays below the divisor while the unit runs
  assert property (@(posedge clk) disable iff (rst) div_run |-> (rem < {1'b0, dsr}))
    else $error("remainder unit out of range");

  // a running unit always has steps left
  assert property (@(posedge clk) disable iff (rst) div_run |-> (cnt != 6'd0))
    else $error("remainder unit ran past its count");

  // a response appears only out of the completion state
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == pdrm_pkg::S_DONE))
    else $error("response without completion");

  // sequence count moves only when a record is published
  assert property (@(posedge clk) disable iff (rst)
    (pcount != $past(pcount)) |-> ($past(state) == pdrm_pkg::S_WR_ADV))
    else $error("sequence count changed outside a publish");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the packet descriptor ring manager.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  pdrm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pdrm_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [32:0] cfg_data = '0;

  packet_descriptor_ring_manager u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the configuration and ring state
  logic [6:0]  m_slots;
  logic [32:0] m_arena;
  logic [32:0] m_limit;
  logic [3:0]  m_align;
  logic [5:0]  m_ptr;
  logic [62:0] m_cursor;
  logic [62:0] m_pubcnt;
  pdrm_pkg::desc_t m_ring [64];
  logic [62:0] m_ring_seq [64];

  pdrm_pkg::rsp_t expected_rsp_q[$];
  int   mismatches = 0;
  int   n_rsp = 0;
  int   n_sent = 0;
  int   status_seen [5];
  int   sender_idle_pct = 0;
  int   receiver_idle_pct = 0;
  int   hold_cycles = 0;

  function automatic int num_slots();
    if (m_slots < 1) return 1;
    if (m_slots > 64) return 64;
    return int'(m_slots);
  endfunction

  function automatic logic [63:0] align_bytes();
    int s;
    s = int'(m_align);
    if (s < 3) s = 3;
    if (s > 12) s = 12;
    return 64'd1 << s;
  endfunction

  function automatic logic [63:0] arena_size();
    logic [63:0] a;
    a = {31'd0, m_arena};
    if (a > 64'h1_0000_0000) a = 64'h1_0000_0000;
    return a & ~(align_bytes() - 64'd1);
  endfunction

  function automatic logic [5:0] slot_mod(longint v);
    longint n;
    n = num_slots();
    return 6'(((v % n) + n) % n);
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [32:0] val);
    case (idx)
      pdrm_pkg::CFG_SLOTS: m_slots = val[6:0];
      pdrm_pkg::CFG_ARENA: m_arena = val;
      pdrm_pkg::CFG_LIMIT: m_limit = val;
      default:             m_align = val[3:0];
    endcase
  endfunction

  // Compute the ring manager's response to one command and update the shadow state
  function automatic pdrm_pkg::rsp_t ring_response(pdrm_pkg::req_t r);
    pdrm_pkg::rsp_t o;
    logic [63:0] arena, al, recsz, stride, phys, start, sum;
    logic [62:0] seq;
    logic [5:0] k;
    pdrm_pkg::desc_t d;
    o = '0;
    arena = arena_size();
    o.slot = m_ptr;
    case (r.cmd)
      pdrm_pkg::CMD_WRITE: begin
        recsz = {32'd0, r.payload_bytes} + {32'd0, r.meta_bytes};
        al = align_bytes();
        if (arena == 0 || recsz == 0) o.status = pdrm_pkg::ST_BAD_SIZE;
        else if (recsz > {31'd0, m_limit}) o.status = pdrm_pkg::ST_TOO_LARGE;
        else begin
          stride = (recsz + al - 1) & ~(al - 1);
          if (stride > arena) o.status = pdrm_pkg::ST_BAD_SIZE;
          else begin
            phys = {1'b0, m_cursor} % arena;
            start = {1'b0, m_cursor};
            if (phys + stride > arena) begin
              start = (start + (arena - phys)) & 64'h7FFF_FFFF_FFFF_FFFF;
              phys = 0;
            end
            seq = m_pubcnt + 63'd1;
            k = m_ptr;
            d.offset = phys[31:0];
            d.payload_len = r.payload_bytes;
            d.meta_len = r.meta_bytes;
            d.start_cursor = start[62:0];
            d.timestamp = r.timestamp;
            d.kind = r.packet_kind;
            d.track = r.track_id;
            d.seq = seq;
            m_ring[k] = d;
            m_ring_seq[k] = seq;
            m_cursor = start[62:0] + stride[62:0];
            m_pubcnt = seq;
            m_ptr = slot_mod(longint'(m_ptr) + 1);
            o.status = pdrm_pkg::ST_OK;
            o.slot = m_ptr;
            o.arena_offset = phys[31:0];
            o.record_cursor = start[62:0];
            o.rec_payload_bytes = r.payload_bytes;
            o.rec_meta_bytes = r.meta_bytes;
            o.rec_kind = r.packet_kind;
            o.rec_track = r.track_id;
            o.rec_timestamp = r.timestamp;
            o.rec_seq = seq;
          end
        end
      end
      pdrm_pkg::CMD_READ: begin
        k = slot_mod(longint'(r.slot_index));
        o.slot = k;
        d = m_ring[k];
        sum = {32'd0, d.offset} + {32'd0, d.meta_len} + {32'd0, d.payload_len};
        if (arena == 0) o.status = pdrm_pkg::ST_BAD_SIZE;
        else if (m_ring_seq[k] == 0) o.status = pdrm_pkg::ST_UNPUB;
        else if (sum > arena) o.status = pdrm_pkg::ST_BAD_SIZE;
        else if ({1'b0, 63'(m_cursor - d.start_cursor)} > arena)
          o.status = pdrm_pkg::ST_LAPPED;
        else begin
          o.status = pdrm_pkg::ST_OK;
          o.arena_offset = d.offset;
          o.record_cursor = d.start_cursor;
          o.rec_payload_bytes = d.payload_len;
          o.rec_meta_bytes = d.meta_len;
          o.rec_kind = d.kind;
          o.rec_track = d.track;
          o.rec_timestamp = d.timestamp;
          o.rec_seq = d.seq;
        end
      end
      pdrm_pkg::CMD_SET: begin
        m_ptr = slot_mod(longint'(r.slot_index));
        o.slot = m_ptr;
      end
      default: o.slot = slot_mod(longint'(m_ptr) + longint'(r.slot_index));
    endcase
    o.cursor_now = m_cursor;
    o.seq_now = m_pubcnt;
    return o;
  endfunction

  // Offer one transaction and predict its response once accepted; valid stays
  // up after the accept until the next transaction, an idle cycle or a drain
  task automatic send_cmd(pdrm_pkg::req_t r);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expected_rsp_q.push_back(ring_response(r));
    n_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, val);
    @(posedge clk);
  endtask

  // Drop valid, drain all responses, then idle a while
  task automatic drain();
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  function automatic pdrm_pkg::req_t make_req(logic [1:0] c, logic [31:0] pay,
                                              logic [31:0] meta, logic [31:0] idx);
    pdrm_pkg::req_t r;
    r.cmd = c;
    r.payload_bytes = pay;
    r.meta_bytes = meta;
    r.packet_kind = 8'($urandom);
    r.track_id = $urandom;
    r.timestamp = {$urandom, $urandom};
    r.slot_index = idx;
    return r;
  endfunction

  function automatic pdrm_pkg::req_t random_req();
    int pick;
    logic [31:0] pay, meta, idx;
    logic [1:0] c;
    pick = $urandom_range(99);
    c = pick < 50 ? pdrm_pkg::CMD_WRITE : pick < 80 ? pdrm_pkg::CMD_READ :
        pick < 90 ? pdrm_pkg::CMD_SET : pdrm_pkg::CMD_QUERY;
    case ($urandom_range(9))
      0: begin pay = $urandom; meta = $urandom; end
      1: begin pay = 0; meta = 0; end
      2: begin pay = $urandom_range(8192); meta = 0; end
      default: begin pay = $urandom_range(3000); meta = $urandom_range(300); end
    endcase
    idx = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(200)) - 32'd100;
    return make_req(c, pay, meta, idx);
  endfunction

  // Compare each response transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp);
      end else begin
        pdrm_pkg::rsp_t e;
        e = expected_rsp_q.pop_front();
        n_rsp++;
        if (e.status < 5) status_seen[e.status]++;
        if (rsp !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", e, rsp);
        end
      end
    end
  end

  // Receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct;
    end
  end

  task automatic test_directed();
    send_cmd(make_req(pdrm_pkg::CMD_READ, 0, 0, 32'd5));
    send_cmd(make_req(pdrm_pkg::CMD_WRITE, 0, 0, 0));
    send_cmd(make_req(pdrm_pkg::CMD_WRITE, 32'd65536, 32'd1, 0));
    send_cmd(make_req(pdrm_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send_cmd(make_req(pdrm_pkg::CMD_WRITE, 32'd1, 0, 32'hFFFF_FFFF));
    send_cmd(make_req(pdrm_pkg::CMD_WRITE, 32'd60000, 32'd5536, 0));
    send_cmd(make_req(pdrm_pkg::CMD_READ, 0, 0, 32'h8000_0000));
    send_cmd(make_req(pdrm_pkg::CMD_READ, 0, 0, 32'h7FFF_FFFF));
    send_cmd(make_req(pdrm_pkg::CMD_READ, 0, 0, 32'hFFFF_FFC0));
    send_cmd(make_req(pdrm_pkg::CMD_SET, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_req(pdrm_pkg::CMD_QUERY, 0, 0, 32'h8000_0000));
    send_cmd(make_req(pdrm_pkg::CMD_QUERY, 0, 0, 32'h7FFF_FFFF));
    send_cmd(make_req(pdrm_pkg::CMD_SET, 0, 0, 0));
    drain();
  endtask

  // Small arena and large alignment: wrap padding and lapped reads
  task automatic test_wrap_and_lap();
    write_reg(pdrm_pkg::CFG_ALIGN, 33'd12);
    write_reg(pdrm_pkg::CFG_ARENA, 33'd20000);
    write_reg(pdrm_pkg::CFG_SLOTS, 33'd5);
    for (int i = 0; i < 200; i++)
      send_cmd(make_req($urandom_range(1) ? pdrm_pkg::CMD_WRITE : pdrm_pkg::CMD_READ,
                        $urandom_range(5000), $urandom_range(100), $urandom_range(20)));
    drain();
    // Shrink below the pointer and the arena below stored records
    write_reg(pdrm_pkg::CFG_SLOTS, 33'd2);
    write_reg(pdrm_pkg::CFG_ARENA, 33'd4096);
    for (int i = 0; i < 30; i++) send_cmd(random_req());
    drain();
    write_reg(pdrm_pkg::CFG_ALIGN, 33'd0);
    write_reg(pdrm_pkg::CFG_ARENA, 33'd0);
    for (int i = 0; i < 20; i++) send_cmd(random_req());
    drain();
    write_reg(pdrm_pkg::CFG_ALIGN, 33'd15);
    write_reg(pdrm_pkg::CFG_ARENA, 33'h1_FFFF_FFFF);
    write_reg(pdrm_pkg::CFG_LIMIT, 33'h1_0000_0000);
    write_reg(pdrm_pkg::CFG_SLOTS, 33'd127);
    for (int i = 0; i < 60; i++) send_cmd(random_req());
    drain();
    write_reg(pdrm_pkg::CFG_SLOTS, 33'd0);
    write_reg(pdrm_pkg::CFG_LIMIT, 33'd0);
    for (int i = 0; i < 20; i++) send_cmd(random_req());
    drain();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    sender_idle_pct = s_pct;
    receiver_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        drain();
        write_reg(pdrm_pkg::CFG_SLOTS, 33'($urandom_range(64, 1)));
        write_reg(pdrm_pkg::CFG_ARENA, $urandom_range(1) ? 33'($urandom_range(40000, 8))
                                                         : {1'b0, $urandom});
        write_reg(pdrm_pkg::CFG_LIMIT, 33'($urandom_range(20000, 1)));
        write_reg(pdrm_pkg::CFG_ALIGN, 33'($urandom_range(12, 3)));
      end
      send_cmd(random_req());
    end
    drain();
  endtask

  // Hold the receiver off while items keep coming so the input backs up
  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) send_cmd(random_req());
    drain();
  endtask

  initial begin
    m_slots = 7'd64;
    m_arena = 33'd1048576;
    m_limit = 33'd65536;
    m_align = 4'd3;
    m_ptr = '0;
    m_cursor = '0;
    m_pubcnt = '0;
    for (int i = 0; i < 64; i++) begin
      m_ring[i] = '0;
      m_ring_seq[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_wrap_and_lap();
    test_backpressure();
    test_random(500, 12, 79);
    test_random(500, 79, 12);
    test_random(500, 0, 0);
    $display("Covered %0d commands, %0d responses checked, over many ring settings.",
             n_sent, n_rsp);
    $display("Status counts ok/too-large/bad-size/unpublished/lapped: %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS packet_descriptor_ring_manager");
    end else begin
      $display("FAIL packet_descriptor_ring_manager");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAIL packet_descriptor_ring_manager");
    $finish;
  end
endmodule
